/* sv/rama_pkg.sv */
`default_nettype none
package rama_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int MAG_W = 2 * OPERAND_WIDTH + 1;
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int PC_W = 4;

  typedef struct packed {
    logic                            operation;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] result_num;
    logic signed [DEN_W-1:0] result_den;
    logic                    zero_divisor;
  } out_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } smag_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_AB,
    OP_MUL_DD,
    OP_MUL_T,
    OP_ADD,
    OP_INIT,
    OP_DIV_XY,
    OP_EUC,
    OP_CAP_G,
    OP_DIV_NG,
    OP_SET_RN,
    OP_DIV_DG,
    OP_SET_RD,
    OP_ZERO,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_MULOP,
    C_Y_ZERO,
    C_X_ZERO,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ctrl_t;

  typedef struct packed {
    logic mulop;
    logic y_zero;
    logic x_zero;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

/* sv/rational_add_multiply_reduce.sv */
// Adds or multiplies two signed fractions and reduces the result by the
// divisor that Euclid's algorithm with truncated remainder yields.
// The input channel (in_valid, in_ready, in_data) takes one item: the
// operation and the four 16-bit operands. The result channel (out_valid,
// out_ready, out_data) returns one item for each input item: the reduced
// numerator, the reduced denominator and the zero divisor flag.
// A microcoded sequencer steps through a 16-word program; the datapath holds
// one 16x16 multiplier, a sign-magnitude adder and a radix-2 divider. The
// Euclid remainder steps share that divider with the two final divisions by
// the common divisor; with both raw parts zero, no division is done. The
// block works on one item at a time; in_ready is high while idle, and the
// next item may be accepted in the cycle after the output register is
// loaded. A finished result is held in the output register until it is
// taken. If the receiver stalls with a result still held, the next item
// waits at its last step. Reset clears the sequencer and the output valid
// flag; no clearing pass is needed.
`default_nettype none
module rational_add_multiply_reduce
  import rama_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  ctrl_t ctrl;
  stat_t stat;
  logic  idle;
  logic  in_fire;

  assign in_ready = idle;
  assign in_fire  = in_valid && idle;

  rama_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .stat  (stat),
    .ctrl  (ctrl),
    .idle  (idle)
  );

  rama_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .in_item   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule
`default_nettype wire

/* sv/rama_div.sv */
`default_nettype none
module rama_div
  import rama_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] dividend,
  input  wire logic [MAG_W-1:0] divisor,
  output logic                  done,
  output logic      [MAG_W-1:0] quo,
  output logic      [MAG_W-1:0] rem
);

  localparam int CW = $clog2(MAG_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [MAG_W-1:0] quo_r;
  logic [MAG_W:0]   rem_r;
  logic [MAG_W-1:0] dvs_r;
  logic [MAG_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_r[MAG_W-1:0], quo_r[MAG_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(MAG_W - 1);
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (fits) begin
        rem_r <= shifted - {1'b0, dvs_r};
        quo_r <= {quo_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r[MAG_W-1:0];

endmodule
`default_nettype wire

/* sv/rama_seq.sv */
`default_nettype none
module rama_seq
  import rama_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire stat_t stat,
  output ctrl_t      ctrl,
  output logic       idle
);

  logic            run_r;
  logic [PC_W-1:0] pc_r;
  ctrl_t           word;
  logic            jump;

  always_comb begin
    unique case (pc_r)
      4'd0:    word = '{OP_MUL_AB, C_NEXT,     4'd0,  1'b0};
      4'd1:    word = '{OP_MUL_DD, C_MULOP,    4'd4,  1'b0};
      4'd2:    word = '{OP_MUL_T,  C_NEXT,     4'd0,  1'b0};
      4'd3:    word = '{OP_ADD,    C_NEXT,     4'd0,  1'b0};
      4'd4:    word = '{OP_INIT,   C_NEXT,     4'd0,  1'b0};
      4'd5:    word = '{OP_NOP,    C_Y_ZERO,   4'd9,  1'b0};
      4'd6:    word = '{OP_DIV_XY, C_NEXT,     4'd0,  1'b0};
      4'd7:    word = '{OP_EUC,    C_DIV_BUSY, 4'd7,  1'b0};
      4'd8:    word = '{OP_NOP,    C_ALWAYS,   4'd5,  1'b0};
      4'd9:    word = '{OP_CAP_G,  C_X_ZERO,   4'd15, 1'b0};
      4'd10:   word = '{OP_DIV_NG, C_NEXT,     4'd0,  1'b0};
      4'd11:   word = '{OP_SET_RN, C_DIV_BUSY, 4'd11, 1'b0};
      4'd12:   word = '{OP_DIV_DG, C_NEXT,     4'd0,  1'b0};
      4'd13:   word = '{OP_SET_RD, C_DIV_BUSY, 4'd13, 1'b0};
      4'd14:   word = '{OP_OUT,    C_OUT_BUSY, 4'd14, 1'b1};
      default: word = '{OP_ZERO,   C_ALWAYS,   4'd14, 1'b0};
    endcase
  end

  always_comb begin
    unique case (word.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_MULOP:    jump = stat.mulop;
      C_Y_ZERO:   jump = stat.y_zero;
      C_X_ZERO:   jump = stat.x_zero;
      C_DIV_BUSY: jump = !stat.div_done;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pc_r  <= '0;
    end else if (!run_r) begin
      pc_r <= '0;
      if (start) begin
        run_r <= 1'b1;
      end
    end else if (jump) begin
      pc_r <= word.target;
    end else begin
      pc_r <= pc_r + 1'b1;
      if (word.last) begin
        run_r <= 1'b0;
      end
    end
  end

  assign ctrl = run_r ? word : '{OP_NOP, C_NEXT, 4'd0, 1'b0};
  assign idle = !run_r;

endmodule
`default_nettype wire

/* sv/rama_dp.sv */
`default_nettype none
module rama_dp
  import rama_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  load,
  input  wire in_t   in_item,
  input  wire ctrl_t ctrl,
  output stat_t      stat,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_t       out_item
);

  localparam int OW = OPERAND_WIDTH;

  typedef struct packed {
    logic          neg;
    logic [OW-1:0] mag;
  } opnd_t;

  function automatic opnd_t split(input logic [OW-1:0] raw);
    opnd_t v;
    v.neg = raw[OW-1];
    v.mag = raw[OW-1] ? (~raw + 1'b1) : raw;
    return v;
  endfunction

  function automatic smag_t sm_add(input smag_t x, input smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    r.neg = r.neg && (r.mag != '0);
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] to_bits(input smag_t v);
    return v.neg ? (~v.mag + 1'b1) : v.mag;
  endfunction

  logic  mulop_r;
  opnd_t an_r, ad_r, bn_r, bd_r;
  smag_t n_r, d_r, t_r, x_r, y_r, g_r, rn_r, rd_r;
  logic  err_r;
  logic  out_valid_r;
  out_t  out_r;

  opnd_t            mx, my;
  smag_t            prod;
  logic             div_start;
  logic [MAG_W-1:0] div_a, div_b;
  logic             div_done;
  logic [MAG_W-1:0] div_q, div_r;
  logic             q_neg;
  logic             out_busy;

  always_comb begin
    unique case (ctrl.op)
      OP_MUL_AB: begin
        mx = an_r;
        my = mulop_r ? bn_r : bd_r;
      end
      OP_MUL_DD: begin
        mx = ad_r;
        my = bd_r;
      end
      default: begin
        mx = ad_r;
        my = bn_r;
      end
    endcase
  end

  always_comb begin
    prod.mag = MAG_W'(mx.mag * my.mag);
    prod.neg = (mx.neg != my.neg) && (prod.mag != '0);
  end

  assign div_start = ctrl.op == OP_DIV_XY || ctrl.op == OP_DIV_NG || ctrl.op == OP_DIV_DG;
  assign div_a = (ctrl.op == OP_DIV_XY) ? x_r.mag : ((ctrl.op == OP_DIV_NG) ? n_r.mag : d_r.mag);
  assign div_b = (ctrl.op == OP_DIV_XY) ? y_r.mag : g_r.mag;

  rama_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  assign out_busy = out_valid_r && !out_ready;
  assign q_neg    = (div_q != '0) && ((ctrl.op == OP_SET_RN ? n_r.neg : d_r.neg) != g_r.neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.op == OP_OUT && !out_busy) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mulop_r <= in_item.operation;
      an_r    <= split(in_item.a_num);
      ad_r    <= split(in_item.a_den);
      bn_r    <= split(in_item.b_num);
      bd_r    <= split(in_item.b_den);
    end
    unique case (ctrl.op)
      OP_MUL_AB: n_r <= prod;
      OP_MUL_DD: d_r <= prod;
      OP_MUL_T:  t_r <= prod;
      OP_ADD:    n_r <= sm_add(n_r, t_r);
      OP_INIT: begin
        x_r   <= n_r;
        y_r   <= d_r;
        err_r <= 1'b0;
      end
      OP_EUC: begin
        if (div_done) begin
          x_r     <= y_r;
          y_r.mag <= div_r;
          y_r.neg <= x_r.neg && (div_r != '0);
        end
      end
      OP_CAP_G: g_r <= x_r;
      OP_SET_RN: begin
        if (div_done) begin
          rn_r <= '{q_neg, div_q};
        end
      end
      OP_SET_RD: begin
        if (div_done) begin
          rd_r <= '{q_neg, div_q};
        end
      end
      OP_ZERO: begin
        rn_r  <= '0;
        rd_r  <= '0;
        err_r <= 1'b1;
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_r.result_num   <= NUM_W'(to_bits(rn_r));
          out_r.result_den   <= DEN_W'(to_bits(rd_r));
          out_r.zero_divisor <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign stat.mulop    = mulop_r;
  assign stat.y_zero   = y_r.mag == '0;
  assign stat.x_zero   = x_r.mag == '0;
  assign stat.div_done = div_done;
  assign stat.out_busy = out_busy;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

/* test/rational_add_multiply_reduce_tb.sv */
`timescale 1ns / 1ps
module rational_add_multiply_reduce_tb;
  import rama_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_PCT = 23;
  localparam int HOLD_CYCLES = 6000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam logic OPER_ADD = 1'b0;
  localparam logic OPER_MUL = 1'b1;
  localparam logic signed [OPERAND_WIDTH-1:0] OPND_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
  localparam logic signed [OPERAND_WIDTH-1:0] OPND_MAX = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t expected_fractions[$];
  out_t next_fraction;
  int   fail_count = 0;
  int   cycle_count = 0;
  logic idling;
  int   hold_request;
  int   hold_seen = 0;
  int   hold_left = 0;

  rational_add_multiply_reduce i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic out_t reduce_fraction(input in_t item);
    longint an, ad, bn, bd, num, den, x, y, r, q;
    out_t res;
    an = item.a_num;
    ad = item.a_den;
    bn = item.b_num;
    bd = item.b_den;
    num = (item.operation == OPER_MUL) ? an * bn : an * bd + ad * bn;
    den = ad * bd;
    x = num;
    y = den;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    res = '0;
    if (x == 0) begin
      res.zero_divisor = 1'b1;
    end else begin
      q = num / x;
      res.result_num = q[NUM_W-1:0];
      q = den / x;
      res.result_den = q[DEN_W-1:0];
    end
    return res;
  endfunction

  function automatic in_t make_item(input logic op,
                                    input logic signed [OPERAND_WIDTH-1:0] an,
                                    input logic signed [OPERAND_WIDTH-1:0] ad,
                                    input logic signed [OPERAND_WIDTH-1:0] bn,
                                    input logic signed [OPERAND_WIDTH-1:0] bd);
    in_t item;
    item.operation = op;
    item.a_num = an;
    item.a_den = ad;
    item.b_num = bn;
    item.b_den = bd;
    return item;
  endfunction

  function automatic logic signed [OPERAND_WIDTH-1:0] random_operand();
    logic signed [OPERAND_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = OPND_MIN;
          1: v = OPND_MAX;
          2: v = 1;
          default: v = -1;
        endcase
      end
      1, 2, 3: begin
        v = OPERAND_WIDTH'($urandom_range(1, 60));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      4: v = '0;
      default: v = OPERAND_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  function automatic in_t random_item();
    return make_item($urandom_range(0, 1) == 1 ? OPER_MUL : OPER_ADD, random_operand(),
                     random_operand(), random_operand(), random_operand());
  endfunction

  task automatic send_fraction(input in_t item);
    while (idling && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_fractions.push_back(reduce_fraction(item));
  endtask

  task automatic test_special_cases();
    send_fraction(make_item(OPER_MUL, 0, 0, 5, 7));
    send_fraction(make_item(OPER_ADD, 0, 3, 0, 0));
    send_fraction(make_item(OPER_ADD, 3, 0, 4, 5));
    send_fraction(make_item(OPER_MUL, -7, 2, 3, 0));
    send_fraction(make_item(OPER_MUL, 0, 4, 9, -6));
    send_fraction(make_item(OPER_ADD, 1, 2, -1, 2));
    send_fraction(make_item(OPER_MUL, -1, 2, 2, 2));
    send_fraction(make_item(OPER_ADD, 1, -3, 1, 6));
  endtask

  task automatic test_operand_extremes();
    for (int op = 0; op < 2; op++) begin
      send_fraction(make_item(op[0], OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN));
      send_fraction(make_item(op[0], OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX));
      send_fraction(make_item(op[0], OPND_MIN, OPND_MAX, OPND_MAX, OPND_MIN));
      send_fraction(make_item(op[0], OPND_MAX, OPND_MIN, OPND_MIN, OPND_MAX));
      send_fraction(make_item(op[0], OPND_MIN, 1, OPND_MIN, 1));
      send_fraction(make_item(op[0], OPND_MAX, -1, OPND_MIN, -1));
    end
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_fraction(random_item());
  endtask

  task automatic test_no_idle_stretch(input int count);
    idling <= 1'b0;
    repeat (count) send_fraction(random_item());
    idling <= 1'b1;
  endtask

  task automatic test_output_backpressure();
    hold_request <= hold_request + 1;
    repeat (6) send_fraction(random_item());
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fractions.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("Result with no item pending: num=%0d den=%0d zero_divisor=%0b",
                     out_data.result_num, out_data.result_den, out_data.zero_divisor);
          end
        end else begin
          next_fraction = expected_fractions.pop_front();
          if (out_data.result_num !== next_fraction.result_num ||
              out_data.result_den !== next_fraction.result_den ||
              out_data.zero_divisor !== next_fraction.zero_divisor) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("Mismatch: expected %0d/%0d zero=%0b, got %0d/%0d zero=%0b",
                       next_fraction.result_num, next_fraction.result_den,
                       next_fraction.zero_divisor, out_data.result_num,
                       out_data.result_den, out_data.zero_divisor);
            end
          end
        end
      end
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idling && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idling = 1'b1;
    hold_request = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_operand_extremes();
    test_random_mix(200);
    test_no_idle_stretch(80);
    test_output_backpressure();
    test_random_mix(30);
    in_valid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* rational_add_multiply_reduce.f */
sv/rama_pkg.sv
sv/rama_div.sv
sv/rama_seq.sv
sv/rama_dp.sv
sv/rational_add_multiply_reduce.sv
test/rational_add_multiply_reduce_tb.sv
